// File: src/lkvc_pkg.sv
package lkvc_pkg;

    localparam int unsigned DepthDef    = 8;
    localparam int unsigned KeyWidthDef = 32;
    localparam int unsigned KeyW        = 32;
    localparam int unsigned ValW        = 32;
    localparam int unsigned CapW        = 4;

    localparam logic [CapW-1:0] CapReset = 4'd8;

    localparam logic ReqInsert = 1'b0;
    localparam logic ReqGet    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_RANK,
        ST_RANK_END,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        RM_NONE,
        RM_PROMOTE,
        RM_AGE
    } t_rank_mode;

    typedef struct packed {
        logic accept;
        logic clr_addr;
        logic rd_en;
        logic rd_scan;
        logic decide;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic addr_last;
        logic need_rank;
        logic out_free;
    } t_status;

endpackage

// File: src/lkvc_req_if.sv
interface lkvc_req_if;
    import lkvc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [KeyW-1:0]        req_key;
    logic signed [ValW-1:0] req_value;

    modport source (output valid, output req_type, output req_key, output req_value,
                    input ready);
    modport sink (input valid, input req_type, input req_key, input req_value,
                  output ready);
endinterface

// File: src/lkvc_rsp_if.sv
interface lkvc_rsp_if;
    import lkvc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   found;
    logic signed [ValW-1:0] read_value;
    logic                   evicted;
    logic                   mru_valid;
    logic [KeyW-1:0]        mru_key;

    modport source (output valid, output found, output read_value, output evicted,
                    output mru_valid, output mru_key, input ready);
    modport sink (input valid, input found, input read_value, input evicted,
                  input mru_valid, input mru_key, output ready);
endinterface

// File: src/lkvc_cfg_if.sv
interface lkvc_cfg_if;
    import lkvc_pkg::*;

    logic            valid;
    logic            ready;
    logic [CapW-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink (input valid, input capacity, output ready);
endinterface

// File: src/lru_key_value_cache_top.sv
// A request's word is loaded after a key scan and a decision for a get miss or an
// update of a present key, and after a further rank pass when recency ranks change.
// A new request is taken only once the last one's word is loaded; the key scan and
// the rank pass each visit one entry per cycle through the single memory read port.
// Reset empties the store at once, clears the output valid bit and sets capacity to eight.
module lru_key_value_cache_top #(
    parameter int unsigned DEPTH     = lkvc_pkg::DepthDef,
    parameter int unsigned KEY_WIDTH = lkvc_pkg::KeyWidthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lkvc_req_if.sink   i_req,
    lkvc_rsp_if.source o_rsp,
    lkvc_cfg_if.sink   i_cfg
);
    import lkvc_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign i_cfg.ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lkvc_dpath #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_req_type     (i_req.req_type),
        .i_req_key      (i_req.req_key),
        .i_req_value    (i_req.req_value),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_capacity (i_cfg.capacity),
        .o_rsp_valid    (o_rsp.valid),
        .i_rsp_ready    (o_rsp.ready),
        .o_found        (o_rsp.found),
        .o_read_value   (o_rsp.read_value),
        .o_evicted      (o_rsp.evicted),
        .o_mru_valid    (o_rsp.mru_valid),
        .o_mru_key      (o_rsp.mru_key)
    );

endmodule

// File: src/lkvc_ctrl.sv
module lkvc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  lkvc_pkg::t_status i_status,
    output lkvc_pkg::t_cmd    o_cmd
);
    import lkvc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.addr_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = i_status.need_rank ? ST_RANK : ST_FINISH;
            end
            ST_RANK: begin
                if (i_status.addr_last) begin
                    n_state = ST_RANK_END;
                end
            end
            ST_RANK_END: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready    = 1'b1;
                o_cmd.clr_addr = 1'b1;
                o_cmd.accept   = i_req_valid;
            end
            ST_SCAN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_scan = 1'b1;
            end
            ST_SCAN_END: begin
                o_cmd.clr_addr = 1'b1;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
            end
            ST_RANK: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_RANK_END: begin
            end
            ST_FINISH: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: src/lkvc_dpath.sv
module lkvc_dpath #(
    parameter int unsigned DEPTH     = lkvc_pkg::DepthDef,
    parameter int unsigned KEY_WIDTH = lkvc_pkg::KeyWidthDef
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lkvc_pkg::t_cmd                       i_cmd,
    output lkvc_pkg::t_status                    o_status,
    input  logic                                 i_req_type,
    input  logic [lkvc_pkg::KeyW-1:0]            i_req_key,
    input  logic signed [lkvc_pkg::ValW-1:0]     i_req_value,
    input  logic                                 i_cfg_valid,
    input  logic [lkvc_pkg::CapW-1:0]            i_cfg_capacity,
    output logic                                 o_rsp_valid,
    input  logic                                 i_rsp_ready,
    output logic                                 o_found,
    output logic signed [lkvc_pkg::ValW-1:0]     o_read_value,
    output logic                                 o_evicted,
    output logic                                 o_mru_valid,
    output logic [lkvc_pkg::KeyW-1:0]            o_mru_key
);
    import lkvc_pkg::*;

    localparam int unsigned IdxW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW   = $clog2(DEPTH + 1);
    localparam int unsigned CmpW   = (CntW > CapW) ? CntW : CapW;
    localparam int unsigned KeyInW = (KEY_WIDTH < KeyW) ? KEY_WIDTH : KeyW;

    localparam logic [IdxW-1:0] LastIdx  = IdxW'(DEPTH - 1);
    localparam logic [CmpW-1:0] DepthCmp = CmpW'(DEPTH);

    logic [KEY_WIDTH-1:0] r_key_mem  [DEPTH];
    logic [ValW-1:0]      r_val_mem  [DEPTH];
    logic [IdxW-1:0]      r_rank_mem [DEPTH];

    logic [DEPTH-1:0]     r_valid;
    logic [CntW-1:0]      r_count;
    logic [CapW-1:0]      r_capacity;

    logic                 r_req_type;
    logic [KEY_WIDTH-1:0] r_req_key;
    logic [ValW-1:0]      r_req_value;

    logic [IdxW-1:0]      r_addr;
    logic                 r_rd_vld;
    logic                 r_rd_scan;
    logic [IdxW-1:0]      r_rd_idx;
    logic [KEY_WIDTH-1:0] r_rd_key;
    logic [ValW-1:0]      r_rd_val;
    logic [IdxW-1:0]      r_rd_rank;

    logic                 r_hit;
    logic [IdxW-1:0]      r_hit_idx;
    logic [IdxW-1:0]      r_hit_rank;
    logic [ValW-1:0]      r_hit_val;
    logic [IdxW-1:0]      r_lru_idx;
    logic                 r_free_found;
    logic [IdxW-1:0]      r_free_idx;
    logic [KEY_WIDTH-1:0] r_mru_old;

    t_rank_mode           r_mode;
    logic [IdxW-1:0]      r_slot;

    logic                 r_res_found;
    logic [ValW-1:0]      r_res_rval;
    logic                 r_res_evict;
    logic                 r_res_mvalid;
    logic [KeyW-1:0]      r_res_mkey;

    logic                 r_out_vld;
    logic                 r_out_found;
    logic [ValW-1:0]      r_out_rval;
    logic                 r_out_evict;
    logic                 r_out_mvalid;
    logic [KeyW-1:0]      r_out_mkey;

    logic                 rd_live;
    logic [CntW-1:0]      cnt_m1;
    logic [CmpW-1:0]      cap_ext;
    logic [CmpW-1:0]      cap_eff;
    logic                 is_get;
    logic                 ins_new;
    logic                 do_evict;
    logic [IdxW-1:0]      slot;
    t_rank_mode           mode;

    logic                 rank_wr;
    logic [IdxW-1:0]      rank_waddr;
    logic [IdxW-1:0]      rank_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CapReset;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_capacity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type  <= i_req_type;
            r_req_key   <= KEY_WIDTH'(i_req_key[KeyInW-1:0]);
            r_req_value <= i_req_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_scan <= 1'b0;
        end else begin
            if (i_cmd.clr_addr) begin
                r_addr <= '0;
            end else if (i_cmd.rd_en && (r_addr != LastIdx)) begin
                r_addr <= r_addr + IdxW'(1);
            end
            r_rd_vld  <= i_cmd.rd_en;
            r_rd_scan <= i_cmd.rd_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_idx  <= r_addr;
            r_rd_key  <= r_key_mem[r_addr];
            r_rd_val  <= r_val_mem[r_addr];
            r_rd_rank <= r_rank_mem[r_addr];
        end
    end

    assign rd_live = r_valid[r_rd_idx];
    assign cnt_m1  = r_count - CntW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.accept) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_mru_old    <= '0;
        end else if (r_rd_vld && r_rd_scan) begin
            if (rd_live && (r_rd_key == r_req_key) && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_rd_idx;
                r_hit_rank <= r_rd_rank;
                r_hit_val  <= r_rd_val;
            end
            if (rd_live && (CntW'(r_rd_rank) == cnt_m1)) begin
                r_lru_idx <= r_rd_idx;
            end
            if (rd_live && (r_rd_rank == '0)) begin
                r_mru_old <= r_rd_key;
            end
            if (!rd_live && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
        end
    end

    always_comb begin
        cap_ext = CmpW'(r_capacity);
        if (cap_ext == '0) begin
            cap_eff = CmpW'(1);
        end else if (cap_ext > DepthCmp) begin
            cap_eff = DepthCmp;
        end else begin
            cap_eff = cap_ext;
        end
        is_get   = (r_req_type == ReqGet);
        ins_new  = (r_req_type == ReqInsert) && !r_hit;
        do_evict = ins_new && (CmpW'(r_count) >= cap_eff) && (r_count != '0);
        if (do_evict && (!r_free_found || (r_lru_idx < r_free_idx))) begin
            slot = r_lru_idx;
        end else begin
            slot = r_free_idx;
        end
        if (is_get && r_hit) begin
            mode = RM_PROMOTE;
        end else if (ins_new) begin
            mode = RM_AGE;
        end else begin
            mode = RM_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_mode  <= RM_NONE;
        end else if (i_cmd.decide) begin
            r_mode <= mode;
            if (ins_new) begin
                if (do_evict) begin
                    r_valid[r_lru_idx] <= 1'b0;
                end
                r_valid[slot] <= 1'b1;
                r_count       <= do_evict ? r_count : r_count + CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_slot       <= slot;
            r_res_found  <= r_hit;
            r_res_rval   <= (is_get && r_hit) ? r_hit_val : '0;
            r_res_evict  <= do_evict;
            r_res_mvalid <= ins_new || (r_count != '0);
            r_res_mkey   <= ((is_get && r_hit) || ins_new) ? KeyW'(r_req_key)
                                                           : KeyW'(r_mru_old);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && ins_new) begin
            r_key_mem[slot] <= r_req_key;
        end
        if (i_cmd.decide && !is_get) begin
            r_val_mem[ins_new ? slot : r_hit_idx] <= r_req_value;
        end
    end

    always_comb begin
        rank_wr    = 1'b0;
        rank_waddr = r_rd_idx;
        rank_wdata = r_rd_rank + IdxW'(1);
        if (i_cmd.decide && ins_new) begin
            rank_wr    = 1'b1;
            rank_waddr = slot;
            rank_wdata = '0;
        end else if (r_rd_vld && !r_rd_scan && rd_live) begin
            unique case (r_mode)
                RM_PROMOTE: begin
                    if (r_rd_idx == r_hit_idx) begin
                        rank_wr    = 1'b1;
                        rank_wdata = '0;
                    end else if (r_rd_rank < r_hit_rank) begin
                        rank_wr = 1'b1;
                    end
                end
                RM_AGE: begin
                    rank_wr = (r_rd_idx != r_slot);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rank_wr) begin
            r_rank_mem[rank_waddr] <= rank_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_found  <= r_res_found;
            r_out_rval   <= r_res_rval;
            r_out_evict  <= r_res_evict;
            r_out_mvalid <= r_res_mvalid;
            r_out_mkey   <= r_res_mkey;
        end
    end

    assign o_status.addr_last = (r_addr == LastIdx);
    assign o_status.need_rank = (mode != RM_NONE);
    assign o_status.out_free  = !r_out_vld || i_rsp_ready;

    assign o_rsp_valid  = r_out_vld;
    assign o_found      = r_out_found;
    assign o_read_value = r_out_rval;
    assign o_evicted    = r_out_evict;
    assign o_mru_valid  = r_out_mvalid;
    assign o_mru_key    = r_out_mkey;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CmpW'(r_count) <= DepthCmp)
        else $error("Entry count exceeds the store depth.");

    a_count_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("Entry count disagrees with the valid bits.");

    a_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide && ins_new |=> r_valid[r_slot])
        else $error("Newly inserted entry is not marked valid.");

    a_evict_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_evict |-> !r_out_found && r_out_mvalid)
        else $error("Eviction reported on a hit or with an empty store.");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !r_out_vld || i_rsp_ready)
        else $error("Output word overwritten before it was taken.");

endmodule

// File: test/lru_key_value_cache_top_tb.sv
`timescale 1ns / 1ps

module lru_key_value_cache_top_tb;
    import lkvc_pkg::*;

    localparam int unsigned Depth       = DepthDef;
    localparam int unsigned CycleLimit  = 300000;
    localparam int unsigned SettleWait  = 2 * Depth + 5;
    localparam int unsigned DirectedRows = 21;
    localparam int unsigned Phases      = 3;
    localparam int unsigned Chunks      = 5;
    localparam int unsigned ChunkItems  = 95;
    localparam int unsigned PoolSize    = 10;

    typedef struct packed {
        logic                   found;
        logic signed [ValW-1:0] read_value;
        logic                   evicted;
        logic                   mru_valid;
        logic [KeyW-1:0]        mru_key;
    } t_cache_result;

    typedef struct packed {
        bit              set_cap;
        logic [CapW-1:0] cap;
        logic            kind;
        logic [KeyW-1:0] key;
        logic [ValW-1:0] value;
        bit              typed;
        t_cache_result   want;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lkvc_req_if req_ch ();
    lkvc_rsp_if rsp_ch ();
    lkvc_cfg_if cfg_ch ();

    lru_key_value_cache_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    logic [KeyW-1:0] shadow_key   [Depth];
    logic [ValW-1:0] shadow_value [Depth];
    logic            shadow_used  [Depth];
    logic [2:0]      shadow_age   [Depth];
    logic [3:0]      shadow_count;
    logic [CapW-1:0] shadow_capacity;

    t_cache_result pending_results[$];
    t_cache_result oldest_result;
    int            failures = 0;
    int            sender_idle_pct = 20;
    int            receiver_stall_pct = 61;
    int unsigned   cycle_count = 0;

    t_directed_row directed_plan [DirectedRows] = '{
        '{1'b0, 4'd0, ReqGet,    32'h0000_0000, 32'h0000_0000, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}},
        '{1'b0, 4'd0, ReqInsert, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000}},
        '{1'b0, 4'd0, ReqInsert, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF}},
        '{1'b0, 4'd0, ReqGet,    32'h0000_0000, 32'h0000_0000, 1'b1,
          '{1'b1, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h0000_0000}},
        '{1'b0, 4'd0, ReqInsert, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000}},
        '{1'b0, 4'd0, ReqGet,    32'hFFFF_FFFF, 32'h1234_5678, 1'b1,
          '{1'b1, 32'h8000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF}},
        '{1'b0, 4'd0, ReqGet,    32'h1234_5678, 32'h0000_0000, 1'b1,
          '{1'b0, 32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF}},
        '{1'b0, 4'd0, ReqInsert, 32'h0000_0001, 32'hA5A5_A5A5, 1'b0, '0},
        '{1'b0, 4'd0, ReqInsert, 32'h0000_0002, 32'h5A5A_5A5A, 1'b0, '0},
        '{1'b0, 4'd0, ReqInsert, 32'h0000_0003, 32'h0000_0001, 1'b0, '0},
        '{1'b0, 4'd0, ReqInsert, 32'h0000_0004, 32'hFFFF_FFFE, 1'b0, '0},
        '{1'b0, 4'd0, ReqInsert, 32'h0000_0005, 32'h0F0F_0F0F, 1'b0, '0},
        '{1'b0, 4'd0, ReqInsert, 32'h0000_0006, 32'hF0F0_F0F0, 1'b0, '0},
        '{1'b0, 4'd0, ReqInsert, 32'h55AA_55AA, 32'h0000_0001, 1'b0, '0},
        '{1'b0, 4'd0, ReqGet,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{1'b1, 4'd0, ReqInsert, 32'hDEAD_BEEF, 32'h1357_9BDF, 1'b0, '0},
        '{1'b0, 4'd0, ReqInsert, 32'hDEAD_BEEF, 32'h8000_0001, 1'b0, '0},
        '{1'b0, 4'd0, ReqGet,    32'h0000_0006, 32'h0000_0000, 1'b0, '0},
        '{1'b1, 4'd15, ReqInsert, 32'h8000_0000, 32'h2468_ACE0, 1'b0, '0},
        '{1'b1, 4'd1, ReqGet,    32'hDEAD_BEEF, 32'h0000_0000, 1'b0, '0},
        '{1'b1, 4'd8, ReqInsert, 32'h0000_0001, 32'h7FFF_FFFE, 1'b0, '0}
    };

    logic [CapW-1:0] capacity_plan [Phases * Chunks] = '{
        4'd1, 4'd15, 4'd2, 4'd0, 4'd3,
        4'd4, 4'd5, 4'd8, 4'd6, 4'd7,
        4'd10, 4'd1, 4'd8, 4'd3, 4'd8
    };

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_cache_result predict_cache_access(input logic kind,
                                                           input logic [KeyW-1:0] key,
                                                           input logic [ValW-1:0] value);
        t_cache_result   res;
        int              hit;
        int              slot;
        logic [CapW-1:0] limit;
        logic [2:0]      old_age;

        res = '0;
        hit = -1;
        slot = -1;
        if (shadow_capacity == '0) begin
            limit = CapW'(1);
        end else if (shadow_capacity > CapW'(Depth)) begin
            limit = CapW'(Depth);
        end else begin
            limit = shadow_capacity;
        end
        for (int i = 0; i < Depth; i++) begin
            if (hit < 0 && shadow_used[i] && shadow_key[i] == key) begin
                hit = i;
            end
        end
        if (kind == ReqGet) begin
            if (hit >= 0) begin
                old_age = shadow_age[hit];
                for (int i = 0; i < Depth; i++) begin
                    if (shadow_used[i] && shadow_age[i] < old_age) begin
                        shadow_age[i] = shadow_age[i] + 3'd1;
                    end
                end
                shadow_age[hit] = '0;
                res.read_value = shadow_value[hit];
            end
        end else if (hit >= 0) begin
            shadow_value[hit] = value;
        end else begin
            if (shadow_count >= limit && shadow_count > 0) begin
                for (int i = 0; i < Depth; i++) begin
                    if (!res.evicted && shadow_used[i] && shadow_age[i] == shadow_count - 1) begin
                        shadow_used[i] = 1'b0;
                        shadow_count = shadow_count - 4'd1;
                        res.evicted = 1'b1;
                    end
                end
            end
            for (int i = 0; i < Depth; i++) begin
                if (slot < 0 && !shadow_used[i]) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                for (int i = 0; i < Depth; i++) begin
                    if (shadow_used[i]) begin
                        shadow_age[i] = shadow_age[i] + 3'd1;
                    end
                end
                shadow_key[slot] = key;
                shadow_value[slot] = value;
                shadow_used[slot] = 1'b1;
                shadow_age[slot] = '0;
                shadow_count = shadow_count + 4'd1;
            end
        end
        res.found = (hit >= 0);
        for (int i = 0; i < Depth; i++) begin
            if (shadow_used[i] && shadow_age[i] == 0) begin
                res.mru_valid = 1'b1;
                res.mru_key = shadow_key[i];
            end
        end
        return res;
    endfunction

    task automatic issue_request(input logic kind, input logic [KeyW-1:0] key,
                                 input logic [ValW-1:0] value, input bit typed,
                                 input t_cache_result typed_result);
        t_cache_result predicted;

        if ($urandom_range(99) < sender_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.req_key <= key;
        req_ch.req_value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = predict_cache_access(kind, key, value);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // The capacity only changes once every response word has come back.
    task automatic write_capacity(input logic [CapW-1:0] cap);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.capacity <= cap;
        do @(posedge i_clk); while (!cfg_ch.ready);
        shadow_capacity = cap;
        cfg_ch.valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("response word with no request outstanding");
                failures++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (rsp_ch.found !== oldest_result.found) begin
                    $error("found: expected %0b, got %0b", oldest_result.found, rsp_ch.found);
                    failures++;
                end
                if (rsp_ch.read_value !== oldest_result.read_value) begin
                    $error("read_value: expected %h, got %h",
                           oldest_result.read_value, rsp_ch.read_value);
                    failures++;
                end
                if (rsp_ch.evicted !== oldest_result.evicted) begin
                    $error("evicted: expected %0b, got %0b",
                           oldest_result.evicted, rsp_ch.evicted);
                    failures++;
                end
                if (rsp_ch.mru_valid !== oldest_result.mru_valid) begin
                    $error("mru_valid: expected %0b, got %0b",
                           oldest_result.mru_valid, rsp_ch.mru_valid);
                    failures++;
                end
                if (rsp_ch.mru_key !== oldest_result.mru_key) begin
                    $error("mru_key: expected %h, got %h", oldest_result.mru_key, rsp_ch.mru_key);
                    failures++;
                end
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    initial begin
        logic [KeyW-1:0] key_pool [PoolSize];
        logic [KeyW-1:0] key;

        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= ReqInsert;
        req_ch.req_key <= '0;
        req_ch.req_value <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.capacity <= CapReset;
        for (int i = 0; i < Depth; i++) begin
            shadow_used[i] = 1'b0;
            shadow_key[i] = '0;
            shadow_value[i] = '0;
            shadow_age[i] = '0;
        end
        shadow_count = '0;
        shadow_capacity = CapReset;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[r]) begin
            if (directed_plan[r].set_cap) begin
                write_capacity(directed_plan[r].cap);
            end
            issue_request(directed_plan[r].kind, directed_plan[r].key, directed_plan[r].value,
                          directed_plan[r].typed, directed_plan[r].want);
        end

        for (int phase = 0; phase < Phases; phase++) begin
            sender_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 61 : 0;
            receiver_stall_pct = (phase == 0) ? 61 : (phase == 1) ? 20 : 0;
            foreach (key_pool[i]) begin
                key_pool[i] = $urandom;
            end
            for (int chunk = 0; chunk < Chunks; chunk++) begin
                write_capacity(capacity_plan[phase * Chunks + chunk]);
                for (int n = 0; n < ChunkItems; n++) begin
                    key = ($urandom_range(99) < 15) ? $urandom
                                                    : key_pool[$urandom_range(PoolSize - 1)];
                    issue_request(($urandom_range(99) < 50) ? ReqGet : ReqInsert, key, $urandom,
                                  1'b0, '0);
                end
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SettleWait) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d response words never arrived", pending_results.size());
            failures++;
        end
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
